>>> rtl/msbbfr_pkg.sv
`timescale 1ns / 1ps

package msbbfr_pkg;

    // command codes carried in tuser of the input beat
    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_GET     = 2'd2,
        CMD_SKIP    = 2'd3
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_WAIT,
        ST_FORM,
        ST_DONE
    } state_t;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BIDX_W  = POS_W - 3;
    localparam int unsigned ACC_W   = VALUE_W + BYTE_W;
    localparam int unsigned FW_W    = 6;

endpackage

>>> rtl/msb_first_bit_field_reader.sv
`timescale 1ns / 1ps

// MSB-first bit field reader over a byte buffer of BUF_BYTES entries. Bytes are
// loaded one per beat, a restart sets the number of valid bits (saturated to
// 8*BUF_BYTES) and rewinds to the top bit of byte 0, then get and skip beats
// take fields of up to 255 bits, of which a get returns the last 32. One beat
// is handled at a time and each input beat gives exactly one output beat.
// Restart, load, skip, a failed get and a zero-length get pass from acceptance
// through an execute state to the done state. A successful get of nonzero length
// also passes a read state for each of the N stored bytes (1 to 5) that hold its
// last 32 bits, then a wait and a form state before the done state, since the
// byte memory delivers one byte per cycle. The next beat is taken while a
// result still waits in the output register. A byte read before it was loaded
// since reset returns undefined bits.
module msb_first_bit_field_reader #(
    parameter int BUF_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte[7:0], bit_count[15:8], total_bits[31:16]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // value[31:0], remaining[47:32]
    output logic [0:0]  m_axis_tuser    // ok[0]
);

    localparam int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int unsigned CAP_BITS = 8 * BUF_BYTES;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUF_BYTES - 1);

    localparam int POS_W   = msbbfr_pkg::POS_W;
    localparam int BYTE_W  = msbbfr_pkg::BYTE_W;
    localparam int COUNT_W = msbbfr_pkg::COUNT_W;
    localparam int VALUE_W = msbbfr_pkg::VALUE_W;
    localparam int BIDX_W  = msbbfr_pkg::BIDX_W;
    localparam int ACC_W   = msbbfr_pkg::ACC_W;
    localparam int FW_W    = msbbfr_pkg::FW_W;

    // byte store
    logic [BYTE_W-1:0] mem [BUF_BYTES];
    logic [BYTE_W-1:0] mem_q_reg;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // control state
    msbbfr_pkg::state_t state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   bits_left_reg, bits_left_next;
    logic [ADDR_W-1:0]  load_addr_reg, load_addr_next;
    logic [2:0]         rd_cnt_reg, rd_cnt_next;
    logic               rd_pending_reg, rd_pending_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // payload
    msbbfr_pkg::cmd_t   cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]   total_reg, total_next;
    logic [BIDX_W-1:0]  rd_byte_reg, rd_byte_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [2:0]         drop_reg, drop_next;
    logic [FW_W-1:0]    width_reg, width_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_ok_reg, res_ok_next;
    logic [POS_W-1:0]   res_remaining_reg, res_remaining_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;
    logic [0:0]         m_tuser_reg, m_tuser_next;

    // field geometry
    logic [POS_W-1:0]   end_pos;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   last_pos;
    logic [FW_W-1:0]    field_w;
    logic [BIDX_W-1:0]  byte_span;
    logic [POS_W-1:0]   restart_bits;
    logic [ACC_W-1:0]   shifted;
    logic [VALUE_W-1:0] field_mask;
    logic [VALUE_W-1:0] formed;

    assign s_axis_tready = (state_reg == msbbfr_pkg::ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // memory ports
    assign wr_en   = (state_reg == msbbfr_pkg::ST_EXEC) && (cmd_reg == msbbfr_pkg::CMD_LOAD);
    assign rd_en   = (state_reg == msbbfr_pkg::ST_READ);
    assign rd_addr = ADDR_W'(rd_byte_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[load_addr_reg] <= data_reg;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // bytes covering the last 32 bits of the field
    always_comb
    begin
        end_pos      = pos_reg + POS_W'(count_reg);
        field_w      = (count_reg > COUNT_W'(VALUE_W)) ? FW_W'(VALUE_W) : FW_W'(count_reg);
        start_pos    = end_pos - POS_W'(field_w);
        last_pos     = end_pos - POS_W'(1);
        byte_span    = last_pos[POS_W-1:3] - start_pos[POS_W-1:3];
        restart_bits = (32'(total_reg) > CAP_BITS) ? POS_W'(CAP_BITS) : total_reg;
    end

    // align the gathered bytes and keep the field bits
    always_comb
    begin
        shifted    = acc_reg >> drop_reg;
        field_mask = (width_reg == FW_W'(VALUE_W)) ? '1
                   : ((VALUE_W'(1) << width_reg) - VALUE_W'(1));
        formed     = shifted[VALUE_W-1:0] & field_mask;
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next         = state_reg;
        pos_next           = pos_reg;
        bits_left_next     = bits_left_reg;
        load_addr_next     = load_addr_reg;
        rd_cnt_next        = rd_cnt_reg;
        rd_pending_next    = (state_reg == msbbfr_pkg::ST_READ);
        m_tvalid_next      = m_tvalid_reg;
        cmd_next           = cmd_reg;
        data_next          = data_reg;
        count_next         = count_reg;
        total_next         = total_reg;
        rd_byte_next       = rd_byte_reg;
        acc_next           = acc_reg;
        drop_next          = drop_reg;
        width_next         = width_reg;
        res_value_next     = res_value_reg;
        res_ok_next        = res_ok_reg;
        res_remaining_next = res_remaining_reg;
        m_tdata_next       = m_tdata_reg;
        m_tuser_next       = m_tuser_reg;

        // shift in the byte read last cycle
        if (rd_pending_reg)
        begin
            acc_next = {acc_reg[ACC_W-BYTE_W-1:0], mem_q_reg};
        end

        // output beat taken
        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            msbbfr_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = msbbfr_pkg::cmd_t'(s_axis_tuser);
                    data_next  = s_axis_tdata[7:0];
                    count_next = s_axis_tdata[15:8];
                    total_next = s_axis_tdata[31:16];
                    state_next = msbbfr_pkg::ST_EXEC;
                end
            end

            msbbfr_pkg::ST_EXEC:
            begin
                res_value_next     = '0;
                res_ok_next        = 1'b1;
                res_remaining_next = bits_left_reg;
                state_next         = msbbfr_pkg::ST_DONE;
                case (cmd_reg)
                    msbbfr_pkg::CMD_RESTART:
                    begin
                        bits_left_next     = restart_bits;
                        pos_next           = '0;
                        load_addr_next     = '0;
                        res_remaining_next = restart_bits;
                    end
                    msbbfr_pkg::CMD_LOAD:
                    begin
                        load_addr_next = (load_addr_reg == LAST_ADDR) ? '0
                                       : load_addr_reg + ADDR_W'(1);
                    end
                    default:
                    begin
                        if (POS_W'(count_reg) > bits_left_reg)
                        begin
                            res_ok_next = 1'b0;
                        end
                        else
                        begin
                            pos_next           = end_pos;
                            bits_left_next     = bits_left_reg - POS_W'(count_reg);
                            res_remaining_next = bits_left_reg - POS_W'(count_reg);
                            if ((cmd_reg == msbbfr_pkg::CMD_GET) && (count_reg != '0))
                            begin
                                rd_byte_next = start_pos[POS_W-1:3];
                                rd_cnt_next  = 3'(byte_span) + 3'd1;
                                drop_next    = 3'(4'd8 - {1'b0, end_pos[2:0]});
                                width_next   = field_w;
                                state_next   = msbbfr_pkg::ST_READ;
                            end
                        end
                    end
                endcase
            end

            msbbfr_pkg::ST_READ:
            begin
                rd_byte_next = rd_byte_reg + BIDX_W'(1);
                rd_cnt_next  = rd_cnt_reg - 3'd1;
                if (rd_cnt_reg == 3'd1)
                begin
                    state_next = msbbfr_pkg::ST_WAIT;
                end
            end

            msbbfr_pkg::ST_WAIT:
            begin
                state_next = msbbfr_pkg::ST_FORM;
            end

            msbbfr_pkg::ST_FORM:
            begin
                res_value_next = formed;
                state_next     = msbbfr_pkg::ST_DONE;
            end

            msbbfr_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_remaining_reg, res_value_reg};
                    m_tuser_next  = res_ok_reg;
                    state_next    = msbbfr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = msbbfr_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msbbfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            bits_left_reg  <= '0;
            load_addr_reg  <= '0;
            rd_cnt_reg     <= '0;
            rd_pending_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            bits_left_reg  <= bits_left_next;
            load_addr_reg  <= load_addr_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_pending_reg <= rd_pending_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        data_reg          <= data_next;
        count_reg         <= count_next;
        total_reg         <= total_next;
        rd_byte_reg       <= rd_byte_next;
        acc_reg           <= acc_next;
        drop_reg          <= drop_next;
        width_reg         <= width_next;
        res_value_reg     <= res_value_next;
        res_ok_reg        <= res_ok_next;
        res_remaining_reg <= res_remaining_next;
        m_tdata_reg       <= m_tdata_next;
        m_tuser_reg       <= m_tuser_next;
    end

endmodule

>>> tb/msb_first_bit_field_reader_checker.sv
`timescale 1ns / 1ps

module msb_first_bit_field_reader_checker #(
    parameter int BUF_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte[7:0], bit_count[15:8], total_bits[31:16]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // value[31:0], remaining[47:32]
    input  logic [0:0]  m_axis_tuser,   // ok[0]
    output int unsigned mismatches,
    output int unsigned outstanding
);

    localparam int unsigned STREAM_CAP = 8 * BUF_BYTES;
    localparam int unsigned PRINT_CAP  = 40;
    localparam int          ADDR_W     = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

    typedef struct packed {
        logic [msbbfr_pkg::VALUE_W-1:0] value;
        logic                           ok;
        logic [15:0]                    remaining;
    } field_beat_t;

    // shadow of the byte buffer and the read pointers
    logic [msbbfr_pkg::BYTE_W-1:0] shadow_bytes [BUF_BYTES];
    int unsigned                   bit_pos;
    int unsigned                   bits_avail;
    int unsigned                   fill_addr;
    field_beat_t                   field_q [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // apply one command to the shadow state and form its output beat
    function automatic field_beat_t take_field(input msbbfr_pkg::cmd_t cmd,
                                               input logic [7:0] byte_in,
                                               input logic [7:0] count,
                                               input logic [15:0] total);
        field_beat_t                   res;
        logic [msbbfr_pkg::BYTE_W-1:0] src;
        res    = '0;
        res.ok = 1'b1;
        case (cmd)
            msbbfr_pkg::CMD_RESTART:
            begin
                bits_avail = (total > STREAM_CAP) ? STREAM_CAP : total;
                bit_pos    = 0;
                fill_addr  = 0;
            end
            msbbfr_pkg::CMD_LOAD:
            begin
                shadow_bytes[ADDR_W'(fill_addr)] = byte_in;
                fill_addr = (fill_addr + 1) % BUF_BYTES;
            end
            default:
            begin
                // too few bits left: nothing moves
                if (count > bits_avail)
                    res.ok = 1'b0;
                else
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        src = shadow_bytes[ADDR_W'((bit_pos >> 3) % BUF_BYTES)];
                        if (cmd == msbbfr_pkg::CMD_GET)
                            res.value = {res.value[msbbfr_pkg::VALUE_W-2:0],
                                         src[3'(7 - (bit_pos & 7))]};
                        bit_pos++;
                    end
                    bits_avail -= count;
                end
            end
        endcase
        res.remaining = 16'(bits_avail);
        return res;
    endfunction

    // watch both channels on every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        field_beat_t want;
        if (!rst_n)
        begin
            field_q.delete();
            bit_pos    = 0;
            bits_avail = 0;
            fill_addr  = 0;
        end
        else
        begin
            // output beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (field_q.size() == 0)
                    report_mismatch("beat with none pending", m_axis_tdata, '0);
                else
                begin
                    want = field_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.value)
                        report_mismatch("value", 48'(m_axis_tdata[31:0]), 48'(want.value));
                    if (m_axis_tuser[0] !== want.ok)
                        report_mismatch("ok", 48'(m_axis_tuser[0]), 48'(want.ok));
                    if (m_axis_tdata[47:32] !== want.remaining)
                        report_mismatch("remaining", 48'(m_axis_tdata[47:32]),
                                        48'(want.remaining));
                end
            end
            // input beat gives exactly one prediction
            if (s_axis_tvalid && s_axis_tready)
                field_q.push_back(take_field(msbbfr_pkg::cmd_t'(s_axis_tuser),
                                             s_axis_tdata[7:0], s_axis_tdata[15:8],
                                             s_axis_tdata[31:16]));
        end
        outstanding = field_q.size();
    end

endmodule

>>> tb/msb_first_bit_field_reader_tb.sv
`timescale 1ns / 1ps

module msb_first_bit_field_reader_tb;

    localparam int BUF_BYTES     = 4096;
    localparam int FILL_BYTES    = 400;
    localparam int RANDOM_BEATS  = 880;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int unsigned STREAM_BITS = 8 * BUF_BYTES;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // data_byte[7:0], bit_count[15:8], total_bits[31:16]
    logic [1:0]  s_axis_tuser;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // value[31:0], remaining[47:32]
    logic [0:0]  m_axis_tuser;   // ok[0]

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned beats_sent     = 0;

    // sender's view of the stream, so that gets stay on loaded bytes
    int unsigned trk_pos   = 0;
    int unsigned trk_left  = 0;
    int unsigned trk_addr  = 0;
    int unsigned trk_bytes = 0;

    always #5 clk = ~clk;

    msb_first_bit_field_reader #(
        .BUF_BYTES (BUF_BYTES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    msb_first_bit_field_reader_checker #(
        .BUF_BYTES (BUF_BYTES)
    ) i_field_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // output side: random stalls plus one long hold-off
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one beat after random idle cycles, return at its handshake edge
    task automatic send_beat(input msbbfr_pkg::cmd_t cmd, input logic [7:0] byte_in,
                             input logic [7:0] count, input logic [15:0] total);
        msbbfr_pkg::cmd_t sent;
        // a get that would reach past the loaded bytes becomes a skip
        sent = cmd;
        if (cmd == msbbfr_pkg::CMD_GET && count <= trk_left
            && trk_pos + count > 8 * trk_bytes)
            sent = msbbfr_pkg::CMD_SKIP;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {total, count, byte_in};
        s_axis_tuser  <= sent;
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        // follow the read position and the loaded prefix
        case (sent)
            msbbfr_pkg::CMD_RESTART:
            begin
                trk_left = (total > STREAM_BITS) ? STREAM_BITS : total;
                trk_pos  = 0;
                trk_addr = 0;
            end
            msbbfr_pkg::CMD_LOAD:
            begin
                if (trk_addr >= trk_bytes)
                    trk_bytes = trk_addr + 1;
                trk_addr = (trk_addr + 1) % BUF_BYTES;
            end
            default:
            begin
                if (count <= trk_left)
                begin
                    trk_pos  += count;
                    trk_left -= count;
                end
            end
        endcase
    endtask

    // stop offering until every result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [7:0] pick_count();
        case ($urandom_range(9))
            0:       return 8'd0;
            1, 2:    return 8'($urandom_range(255));
            3:       return 8'($urandom_range(64, 33));
            default: return 8'($urandom_range(32, 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_total();
        case ($urandom_range(7))
            0:       return 16'($urandom_range(64));
            1, 2:    return 16'($urandom_range(2000, 65));
            3:       return 16'($urandom_range(32768));
            4:       return 16'($urandom);
            5:
            begin
                case ($urandom_range(4))
                    0:       return 16'd0;
                    1:       return 16'd32767;
                    2:       return 16'd32768;
                    3:       return 16'd32769;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(600, 200));
        endcase
    endfunction

    // mostly restart, a few loads, then a run of gets and skips; some noise
    task automatic run_sequence();
        int unsigned n_loads;
        int unsigned n_fields;
        n_loads  = $urandom_range(8);
        n_fields = $urandom_range(20, 4);
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(6, 1))
                send_beat(msbbfr_pkg::cmd_t'($urandom_range(3)), 8'($urandom),
                          pick_count(), pick_total());
        end
        else
        begin
            send_beat(msbbfr_pkg::CMD_RESTART, 8'($urandom), 8'($urandom), pick_total());
            repeat (n_loads)
                send_beat(msbbfr_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
            repeat (n_fields)
                send_beat(($urandom_range(9) < 7) ? msbbfr_pkg::CMD_GET
                                                  : msbbfr_pkg::CMD_SKIP,
                          8'($urandom), pick_count(), 16'($urandom));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int unsigned phase_end;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= msbbfr_pkg::CMD_RESTART;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stream after reset, then restarts above, at and below the saturation limit
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd0, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'hFF, 8'd1, 16'hFFFF);
        send_beat(msbbfr_pkg::CMD_SKIP, 8'h00, 8'd255, 16'd0);
        send_beat(msbbfr_pkg::CMD_RESTART, 8'h00, 8'd0, 16'hFFFF);
        send_beat(msbbfr_pkg::CMD_RESTART, 8'h00, 8'd0, 16'd32769);
        send_beat(msbbfr_pkg::CMD_RESTART, 8'h00, 8'd0, 16'd32768);
        send_beat(msbbfr_pkg::CMD_RESTART, 8'h00, 8'd0, 16'd0);

        // fill the front of the buffer
        for (int i = 0; i < FILL_BYTES; i++)
        begin
            if (i == 0 || i == FILL_BYTES - 2)
                send_beat(msbbfr_pkg::CMD_LOAD, 8'h00, 8'($urandom), 16'($urandom));
            else if (i == 1 || i == FILL_BYTES - 1)
                send_beat(msbbfr_pkg::CMD_LOAD, 8'hFF, 8'($urandom), 16'($urandom));
            else
                send_beat(msbbfr_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
        end

        // long and short fields, zero lengths
        send_beat(msbbfr_pkg::CMD_RESTART, 8'h00, 8'd0, 16'hFFFF);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd255, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd32, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd1, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd0, 16'd0);
        send_beat(msbbfr_pkg::CMD_SKIP, 8'h00, 8'd0, 16'd0);
        send_beat(msbbfr_pkg::CMD_SKIP, 8'h00, 8'd255, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd31, 16'd0);

        // running out of bits
        send_beat(msbbfr_pkg::CMD_RESTART, 8'h00, 8'd0, 16'd100);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd64, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd37, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd36, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd1, 16'd0);
        send_beat(msbbfr_pkg::CMD_SKIP, 8'h00, 8'd1, 16'd0);
        send_beat(msbbfr_pkg::CMD_GET, 8'h00, 8'd0, 16'd0);

        // skip to the very last bit of a full-length stream
        send_beat(msbbfr_pkg::CMD_RESTART, 8'h00, 8'd0, 16'd32768);
        repeat (128)
            send_beat(msbbfr_pkg::CMD_SKIP, 8'h00, 8'd255, 16'd0);
        send_beat(msbbfr_pkg::CMD_SKIP, 8'h00, 8'd128, 16'd0);
        send_beat(msbbfr_pkg::CMD_SKIP, 8'h00, 8'd1, 16'd0);
        drain();

        // random sequences under each idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_left      = HOLD_CYCLES;
                end
                1:
                begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            phase_end = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < phase_end)
                run_sequence();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop if the run hangs
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
